// ===== design/hash_table_kv_store_macros.svh =====
// ============================================================================
// Assertion macros for the key-value table
// Shared wrappers that put the clock and the reset qualifier on each check.
// ============================================================================
`ifndef HASH_TABLE_KV_STORE_MACROS_SVH
`define HASH_TABLE_KV_STORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define HKV_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define HKV_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/hkv_pkg.sv =====
// ============================================================================
// Key-value table package
// Sizes, operation and status codes, and the request type queued between
// the front and back parts.
// ============================================================================
package hkv_pkg;

    // Table geometry; the depth is a power of two so the slot index wraps.
    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_BYTES   = 8;

    // Field widths.
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int TAG_W    = KEY_W + 1;

    // Key bits that take part in hashing, storing and comparing.
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

    // Hash constants.
    localparam logic [63:0] HASH_SEED  = 64'd5381;
    localparam int          HASH_SHIFT = 5;

    // Probe window.
    localparam int CFG_W     = 4;
    localparam int PROBE_MAX = 8;
    localparam int CNT_W     = $clog2(PROBE_MAX + 1);
    localparam logic [CFG_W-1:0] PROBE_LIMIT_RESET = CFG_W'(5);

    // Request queue.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Register map.
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_PROBE_LIMIT = 1'd0;

    // A classified request waiting for the back part.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] start;
    } req_t;

endpackage

// ===== design/hkv_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module hkv_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/hkv_fifo.sv =====
// ============================================================================
// Request queue
// Short queue that lets the front and back parts stall independently.
// ============================================================================
module hkv_fifo
    import hkv_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  req_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output req_t pop_data
);

    req_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/hkv_front.sv =====
// ============================================================================
// Request front end
// Accepts request transactions, masks the key and hashes it to a start slot.
// ============================================================================
module hkv_front
    import hkv_pkg::*;
(
    input  logic              init_done,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_operation,
    input  logic [KEY_W-1:0]  s_key,
    input  logic [VAL_W-1:0]  s_value,
    output logic              push_valid,
    input  logic              push_ready,
    output req_t              push_data
);

    // djb2 over the key bytes; only the slot bits of the hash are kept,
    // since the table depth is a power of two.
    function automatic logic [SLOT_W-1:0] slot_hash(input logic [KEY_W-1:0] k);
        logic [SLOT_W-1:0] h;
        logic [7:0]        b;
        logic [63:0]       sx;
        h = HASH_SEED[SLOT_W-1:0];
        for (int i = 0; i < KEY_BYTES; i++) begin
            b  = k[8*i +: 8];
            sx = {{56{b[7]}}, b};
            h  = (h << HASH_SHIFT) + h + sx[SLOT_W-1:0];
        end
        return h;
    endfunction

    logic [KEY_W-1:0] key_masked;

    assign key_masked = s_key & KEY_MASK;

    // Nothing is taken until the valid bits have been swept clear.
    assign s_ready    = init_done && push_ready;
    assign push_valid = s_valid && init_done;

    always_comb begin
        push_data.op    = s_operation;
        push_data.key   = key_masked;
        push_data.value = s_value;
        push_data.start = slot_hash(key_masked);
    end

endmodule

// ===== design/hkv_back.sv =====
// ============================================================================
// Table back end
// Probes the table one slot per cycle, then applies the update and
// registers the result transaction.
// ============================================================================
`include "hash_table_kv_store_macros.svh"

module hkv_back
    import hkv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CFG_W-1:0]    probe_limit,
    output logic                init_done,
    input  logic                q_valid,
    output logic                q_pop,
    input  req_t                q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [VAL_W-1:0]    m_read_value
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   clr_addr_reg, clr_addr_next;
    req_t                req_reg, req_next;
    logic [CNT_W-1:0]    win_reg, win_next;
    logic [SLOT_W-1:0]   issue_addr_reg, issue_addr_next;
    logic [CNT_W-1:0]    issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]    eval_cnt_reg, eval_cnt_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0]   eval_addr_reg, eval_addr_next;
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   hit_slot_reg, hit_slot_next;
    logic [VAL_W-1:0]    hit_val_reg, hit_val_next;
    logic                free_reg, free_next;
    logic [SLOT_W-1:0]   free_slot_reg, free_slot_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [VAL_W-1:0]    out_value_reg, out_value_next;

    logic                out_load;
    logic [CNT_W-1:0]    window;
    logic                tag_we;
    logic [SLOT_W-1:0]   tag_waddr;
    logic [TAG_W-1:0]    tag_wdata;
    logic [TAG_W-1:0]    tag_rdata;
    logic                val_we;
    logic [SLOT_W-1:0]   val_waddr;
    logic [VAL_W-1:0]    val_rdata;

    // Tag memory holds the valid bit above the key.
    hkv_ram #(
        .WIDTH (TAG_W),
        .DEPTH (TABLE_DEPTH)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (issue_addr_reg),
        .rdata (tag_rdata)
    );

    hkv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (req_reg.value),
        .raddr (issue_addr_reg),
        .rdata (val_rdata)
    );

    // Probe window: zero counts as one, anything above the maximum as the maximum.
    always_comb begin
        if (probe_limit == '0) begin
            window = CNT_W'(1);
        end else if (CNT_W'(probe_limit) > CNT_W'(PROBE_MAX)) begin
            window = CNT_W'(PROBE_MAX);
        end else begin
            window = CNT_W'(probe_limit);
        end
    end

    assign init_done    = (state_reg != S_CLEAR);
    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign out_load     = (state_reg == S_DONE) && (!out_valid_reg || m_ready);
    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_read_value = out_value_reg;

    // Sequencer: clearing sweep, probe pipeline and write-back.
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        req_next        = req_reg;
        win_next        = win_reg;
        issue_addr_next = issue_addr_reg;
        issue_cnt_next  = issue_cnt_reg;
        eval_cnt_next   = eval_cnt_reg;
        rd_vld_next     = 1'b0;
        eval_addr_next  = eval_addr_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        hit_val_next    = hit_val_reg;
        free_next       = free_reg;
        free_slot_next  = free_slot_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        tag_we          = 1'b0;
        tag_waddr       = clr_addr_reg;
        tag_wdata       = '0;
        val_we          = 1'b0;
        val_waddr       = hit_slot_reg;

        unique case (state_reg)
            S_CLEAR: begin
                tag_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SLOT_W'(TABLE_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    req_next        = q_data;
                    win_next        = window;
                    issue_addr_next = q_data.start;
                    issue_cnt_next  = '0;
                    eval_cnt_next   = '0;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                    state_next      = S_PROBE;
                end
            end
            S_PROBE: begin
                // Issue the next slot read while the previous one is evaluated.
                if (issue_cnt_reg < win_reg) begin
                    rd_vld_next     = 1'b1;
                    eval_addr_next  = issue_addr_reg;
                    issue_addr_next = issue_addr_reg + 1'b1;
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (tag_rdata[TAG_W-1]) begin
                        if (!hit_reg && tag_rdata[KEY_W-1:0] == req_reg.key) begin
                            hit_next      = 1'b1;
                            hit_slot_next = eval_addr_reg;
                            hit_val_next  = val_rdata;
                        end
                    end else if (!free_reg) begin
                        free_next      = 1'b1;
                        free_slot_next = eval_addr_reg;
                    end
                    eval_cnt_next = eval_cnt_reg + 1'b1;
                    if (eval_cnt_reg + 1'b1 == win_reg) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_NOT_FOUND;
                    out_value_next  = '0;
                    state_next      = S_IDLE;
                    unique case (req_reg.op)
                        OP_READ: begin
                            if (hit_reg) begin
                                out_status_next = ST_OK;
                                out_value_next  = hit_val_reg;
                            end
                        end
                        OP_WRITE: begin
                            if (hit_reg) begin
                                val_we          = 1'b1;
                                val_waddr       = hit_slot_reg;
                                out_status_next = ST_OK;
                            end else if (free_reg) begin
                                tag_we          = 1'b1;
                                tag_waddr       = free_slot_reg;
                                tag_wdata       = {1'b1, req_reg.key};
                                val_we          = 1'b1;
                                val_waddr       = free_slot_reg;
                                out_status_next = ST_OK;
                            end else begin
                                out_status_next = ST_FULL;
                            end
                        end
                        OP_DELETE: begin
                            if (hit_reg) begin
                                tag_we          = 1'b1;
                                tag_waddr       = hit_slot_reg;
                                tag_wdata       = {1'b0, req_reg.key};
                                out_status_next = ST_OK;
                            end
                        end
                        default: begin
                            out_status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request context and result payload.
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        win_reg        <= win_next;
        issue_addr_reg <= issue_addr_next;
        issue_cnt_reg  <= issue_cnt_next;
        eval_cnt_reg   <= eval_cnt_next;
        eval_addr_reg  <= eval_addr_next;
        hit_reg        <= hit_next;
        hit_slot_reg   <= hit_slot_next;
        hit_val_reg    <= hit_val_next;
        free_reg       <= free_next;
        free_slot_reg  <= free_slot_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    // The evaluation count never reaches the window while probing.
    `HKV_ASSERT_NOW(a_probe_bound, state_reg == S_PROBE, eval_cnt_reg < win_reg,
        "probe ran past its window")

    // A loaded result leaves the back end idle with a valid output.
    `HKV_ASSERT_NEXT(a_result_loaded, out_load, (state_reg == S_IDLE) && out_valid_reg,
        "result load did not complete")

    // During the clearing sweep no request is taken and no result is shown.
    `HKV_ASSERT_NOW(a_clear_quiet, state_reg == S_CLEAR, !q_pop && !out_valid_reg,
        "activity during clearing sweep")

    // A hit slot and a free slot in one window are always distinct slots.
    `HKV_ASSERT_NOW(a_hit_free_distinct, (state_reg == S_DONE) && hit_reg && free_reg,
        hit_slot_reg != free_slot_reg, "hit and free slot coincide")

endmodule

// ===== design/hash_table_kv_store.sv =====
// ============================================================================
// Hash table key-value store
// Open-addressed key-value table with djb2 hashing and linear probing.
// ============================================================================
// After reset the block sweeps the tag memory to clear every valid bit, one
// slot per cycle; s_axis_tready stays low until the sweep is done, while
// probe_limit writes are taken as usual. Each request transaction is hashed
// on entry and held in a two-entry queue; the back end then picks it up,
// probes the window of slots, where the window is probe_limit with zero taken
// as one and anything above 8 taken as 8 (the reset probe limit is 5), waits
// out the registered read of the last slot, then applies the update and
// registers the result. The probe rate is set by the single read port of the
// tag memory, which returns one slot per cycle. A result that is not taken
// holds the back end until m_axis_tready is high. Each request gives exactly
// one result transaction.
// ============================================================================
module hash_table_kv_store
    import hkv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [127:0]         s_axis_tdata,  // key [63:0], value [127:64]
    input  logic [OP_W-1:0]      s_axis_tuser,  // operation [1:0]
    // Result channel.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,  // read_value [63:0]
    output logic [STATUS_W-1:0]  m_axis_tuser,  // status [1:0]
    // Configuration port.
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [CFG_W-1:0] probe_limit_reg, probe_limit_next;
    logic             cfg_write;
    logic             init_done;
    logic             push_valid;
    logic             push_ready;
    req_t             push_data;
    logic             q_valid;
    logic             q_pop;
    req_t             q_data;

    // Register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        probe_limit_next = probe_limit_reg;
        if (cfg_write && paddr[PADDR_W-1:2] == REG_PROBE_LIMIT) begin
            probe_limit_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_limit_reg <= PROBE_LIMIT_RESET;
        end else begin
            probe_limit_reg <= probe_limit_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_PROBE_LIMIT) begin
            prdata = {{(32 - CFG_W){1'b0}}, probe_limit_reg};
        end
    end

    hkv_front u_front (
        .init_done   (init_done),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_operation (s_axis_tuser),
        .s_key       (s_axis_tdata[KEY_W-1:0]),
        .s_value     (s_axis_tdata[KEY_W +: VAL_W]),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    hkv_fifo u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_data   (q_data)
    );

    hkv_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .probe_limit  (probe_limit_reg),
        .init_done    (init_done),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_data       (q_data),
        .m_valid      (m_axis_tvalid),
        .m_ready      (m_axis_tready),
        .m_status     (m_axis_tuser),
        .m_read_value (m_axis_tdata)
    );

endmodule
